// ===== rtl/sed_pkg.sv =====
package sed_pkg;

  localparam int NRES = 4;
  localparam int CNT_W = $clog2(NRES + 1);

  typedef enum logic [2:0] {
    MODE_FINISHED = 3'd0,
    MODE_NORMAL   = 3'd1,
    MODE_ESCAPE   = 3'd2,
    MODE_HEX      = 3'd3,
    MODE_UNICODE  = 3'd4,
    MODE_DECIMAL  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNTERM  = 2'd0,
    ERR_HEX     = 2'd1,
    ERR_UNICODE = 2'd2,
    ERR_DECIMAL = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    err_t       error_code;
  } item_t;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ESC    = 8'h1b;

  localparam logic [24:0] CP_LIMIT = 25'h110000;

  function automatic item_t data_item(input logic [7:0] b);
    return '{kind: KIND_DATA, data_byte: b, error_code: ERR_UNTERM};
  endfunction

  function automatic item_t err_item(input err_t e);
    return '{kind: KIND_ERROR, data_byte: 8'h00, error_code: e};
  endfunction

  function automatic item_t end_item();
    return '{kind: KIND_END, data_byte: 8'h00, error_code: ERR_UNTERM};
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, b[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, b[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  // {valid, byte} for the single-character escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_APOS:   r = {1'b1, CH_APOS};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      "a":       r = {1'b1, 8'h07};
      "b":       r = {1'b1, 8'h08};
      "e":       r = {1'b1, CH_ESC};
      "f":       r = {1'b1, 8'h0c};
      "n":       r = {1'b1, CH_LF};
      "r":       r = {1'b1, CH_CR};
      "t":       r = {1'b1, 8'h09};
      "v":       r = {1'b1, 8'h0b};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sed_ifs.sv =====
interface sed_in_if;
  import sed_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       first;
  logic       end_of_input;

  modport source (output valid, source_byte, first, end_of_input, input ready);
  modport sink   (input valid, source_byte, first, end_of_input, output ready);
endinterface

interface sed_out_if;
  import sed_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] data_byte;
  err_t       error_code;
  logic       last;

  modport source (output valid, kind, data_byte, error_code, last, input ready);
  modport sink   (input valid, kind, data_byte, error_code, last, output ready);
endinterface

// ===== rtl/string_literal_escape_decoder.sv =====
// Decodes the body of a double-quoted string literal, one source byte per
// request, into content bytes (escapes resolved, \u and \U written as UTF-8),
// then an end item at the closing quote or an error item. Each request is
// decoded in the cycle it is accepted and its results land in a four-entry
// result buffer; the input is ready again once the buffer is down to its
// last entry and that entry is being taken. A byte that yields several results
// (up to four, from a UTF-8 sequence or a short decimal escape) holds the
// input while the buffer drains one item per cycle, or none while the output
// is stalled. After an end or an error, bytes are accepted and dropped until
// one arrives with first set.
module string_literal_escape_decoder (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    src,
  sed_out_if.source dst
);
  import sed_pkg::*;

  mode_t       mode, mode_next;
  logic [20:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [3:0]  need, need_next;

  mode_t       m;
  logic [20:0] acc_e;
  logic [3:0]  cnt_e;
  logic [3:0]  need_e;

  logic [7:0]  b;
  logic        eoi;
  logic [4:0]  hx;
  logic        hex_ok;
  logic [3:0]  hv;
  logic [8:0]  esc;
  logic        is_dec;
  logic [3:0]  dv;

  logic [24:0] uni_acc;
  logic        uni_big;
  logic [3:0]  uni_cnt;
  logic        uni_done;
  logic [20:0] cp;
  logic        cp_surr;

  logic [11:0] dec_acc;
  logic [3:0]  dec_cnt;
  logic        dec_done;
  logic        dec_big;

  logic        nb_has;
  item_t       nb_item;
  mode_t       nb_mode;

  item_t          res [NRES];
  logic [CNT_W-1:0] nres;

  item_t          res_q [NRES];
  logic [CNT_W-1:0] count;

  logic accept;
  logic pop;

  // first clears the state before the byte is decoded
  assign m      = src.first ? MODE_NORMAL : mode;
  assign acc_e  = src.first ? '0 : acc;
  assign cnt_e  = src.first ? '0 : cnt;
  assign need_e = src.first ? '0 : need;

  assign b      = src.source_byte;
  assign eoi    = src.end_of_input;
  assign hx     = hex_digit(b);
  assign hex_ok = !eoi && hx[4];
  assign hv     = hx[3:0];
  assign esc    = simple_escape(b);
  assign is_dec = !eoi && (b inside {[8'h30:8'h39]});
  assign dv     = b[3:0];

  assign uni_acc  = {acc_e, hv};
  assign uni_big  = uni_acc >= CP_LIMIT;
  assign uni_cnt  = cnt_e + 4'd1;
  assign uni_done = uni_cnt >= need_e;
  assign cp       = uni_acc[20:0];
  assign cp_surr  = (cp[20:16] == 5'd0) && (cp[15:11] == 5'b11011);

  assign dec_acc  = {4'd0, acc_e[7:0]} * 12'd10 + {8'd0, dv};
  assign dec_cnt  = cnt_e + 4'd1;
  assign dec_done = dec_cnt >= 4'd3;
  assign dec_big  = |dec_acc[11:8];

  // plain byte handling, shared by normal mode and the tail of a short decimal
  always_comb begin
    nb_has  = 1'b1;
    nb_item = data_item(b);
    nb_mode = MODE_NORMAL;
    if (eoi || b == CH_LF || b == CH_CR) begin
      nb_item = err_item(ERR_UNTERM);
      nb_mode = MODE_FINISHED;
    end else if (b == CH_QUOTE) begin
      nb_item = end_item();
      nb_mode = MODE_FINISHED;
    end else if (b == CH_BSLASH) begin
      nb_has  = 1'b0;
      nb_mode = MODE_ESCAPE;
    end
  end

  // next state
  always_comb begin
    mode_next = m;
    acc_next  = acc_e;
    cnt_next  = cnt_e;
    need_next = need_e;
    case (m)
      MODE_NORMAL: mode_next = nb_mode;
      MODE_ESCAPE: begin
        if (eoi) begin
          mode_next = MODE_FINISHED;
        end else if (esc[8]) begin
          mode_next = MODE_NORMAL;
        end else if (b == "x") begin
          mode_next = MODE_HEX;
          acc_next  = '0;
          cnt_next  = '0;
        end else if (b == "u" || b == "U") begin
          mode_next = MODE_UNICODE;
          acc_next  = '0;
          cnt_next  = '0;
          need_next = (b == "u") ? 4'd4 : 4'd8;
        end else if (is_dec) begin
          mode_next = MODE_DECIMAL;
          acc_next  = {17'd0, dv};
          cnt_next  = 4'd1;
        end else begin
          mode_next = MODE_FINISHED;
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          mode_next = MODE_FINISHED;
        end else if (cnt_e == 4'd0) begin
          acc_next = {17'd0, hv};
          cnt_next = 4'd1;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_UNICODE: begin
        if (!hex_ok) begin
          mode_next = MODE_FINISHED;
        end else begin
          acc_next = cp;
          if (uni_big) begin
            mode_next = MODE_FINISHED;
          end else begin
            cnt_next = uni_cnt;
            if (uni_done) begin
              mode_next = cp_surr ? MODE_FINISHED : MODE_NORMAL;
            end
          end
        end
      end
      MODE_DECIMAL: begin
        if (is_dec) begin
          acc_next = {9'd0, dec_acc};
          cnt_next = dec_cnt;
          if (dec_done) begin
            mode_next = dec_big ? MODE_FINISHED : MODE_NORMAL;
          end
        end else begin
          mode_next = nb_mode;
        end
      end
      default: mode_next = MODE_FINISHED;
    endcase
  end

  // results of this byte
  always_comb begin
    for (int i = 0; i < NRES; i++) begin
      res[i] = data_item(8'h00);
    end
    nres = '0;
    case (m)
      MODE_NORMAL: begin
        res[0] = nb_item;
        nres   = nb_has ? CNT_W'(1) : CNT_W'(0);
      end
      MODE_ESCAPE: begin
        if (eoi) begin
          res[0] = err_item(ERR_UNTERM);
          nres   = CNT_W'(1);
        end else if (esc[8]) begin
          res[0] = data_item(esc[7:0]);
          nres   = CNT_W'(1);
        end else if (!(b == "x" || b == "u" || b == "U" || is_dec)) begin
          res[0] = err_item(ERR_DECIMAL);
          nres   = CNT_W'(1);
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          res[0] = err_item(ERR_HEX);
          nres   = CNT_W'(1);
        end else if (cnt_e != 4'd0) begin
          res[0] = data_item({acc_e[3:0], hv});
          nres   = CNT_W'(1);
        end
      end
      MODE_UNICODE: begin
        if (!hex_ok || uni_big) begin
          res[0] = err_item(ERR_UNICODE);
          nres   = CNT_W'(1);
        end else if (uni_done) begin
          if (cp[20:7] == 14'd0) begin
            res[0] = data_item(cp[7:0]);
            nres   = CNT_W'(1);
          end else if (cp[20:11] == 10'd0) begin
            res[0] = data_item({3'b110, cp[10:6]});
            res[1] = data_item({2'b10, cp[5:0]});
            nres   = CNT_W'(2);
          end else if (|cp[20:16]) begin
            res[0] = data_item({5'b11110, cp[20:18]});
            res[1] = data_item({2'b10, cp[17:12]});
            res[2] = data_item({2'b10, cp[11:6]});
            res[3] = data_item({2'b10, cp[5:0]});
            nres   = CNT_W'(4);
          end else if (cp_surr) begin
            res[0] = err_item(ERR_UNICODE);
            nres   = CNT_W'(1);
          end else begin
            res[0] = data_item({4'b1110, cp[15:12]});
            res[1] = data_item({2'b10, cp[11:6]});
            res[2] = data_item({2'b10, cp[5:0]});
            nres   = CNT_W'(3);
          end
        end
      end
      MODE_DECIMAL: begin
        if (is_dec) begin
          if (dec_done) begin
            res[0] = dec_big ? err_item(ERR_DECIMAL) : data_item(dec_acc[7:0]);
            nres   = CNT_W'(1);
          end
        end else begin
          // short escape: flush the value, then treat the byte as plain
          res[0] = data_item(acc_e[7:0]);
          res[1] = nb_item;
          nres   = nb_has ? CNT_W'(2) : CNT_W'(1);
        end
      end
      default: nres = '0;
    endcase
  end

  assign pop       = dst.valid && dst.ready;
  assign src.ready = (count == '0) || (count == CNT_W'(1) && dst.ready);
  assign accept    = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FINISHED;
      acc  <= '0;
      cnt  <= '0;
      need <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      need <= need_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= nres;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NRES; i++) begin
        res_q[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < NRES - 1; i++) begin
        res_q[i] <= res_q[i + 1];
      end
    end
  end

  assign dst.valid      = (count != '0);
  assign dst.kind       = res_q[0].kind;
  assign dst.data_byte  = res_q[0].data_byte;
  assign dst.error_code = res_q[0].error_code;
  assign dst.last       = (count == CNT_W'(1));

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NRES))
    else $error("result buffer overfilled");

  a_results_shown: assert property (@(posedge clk) disable iff (rst)
    accept && nres != '0 |=> dst.valid)
    else $error("accepted results not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    dst.valid && !dst.ready |=> $stable(count))
    else $error("buffer changed while output stalled");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dst.kind != KIND_DATA |-> dst.last)
    else $error("end or error item not last");

endmodule

// ===== test/string_literal_escape_decoder_checker.sv =====
module string_literal_escape_decoder_checker (
  input  logic clk,
  input  logic rst,
  sed_in_if    in_ch,
  sed_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sed_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    err_t       error_code;
    logic       last;
  } decoded_t;

  // decoder state as the block should hold it
  mode_t       mode;
  logic [20:0] acc;
  logic [3:0]  ndig;
  logic [3:0]  nneed;

  decoded_t decoded_q[$];
  decoded_t want;
  int       batch;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, b[3:0]};
    if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // at most NRES results per request; later ones are dropped
  function automatic void push_result(input kind_t k, input logic [7:0] d, input err_t e);
    if (batch < NRES) begin
      decoded_q.push_back('{kind: k, data_byte: d, error_code: e, last: 1'b0});
      batch++;
    end
  endfunction

  function automatic void flag_error(input err_t e);
    mode = MODE_FINISHED;
    push_result(KIND_ERROR, 8'h00, e);
  endfunction

  function automatic void plain_byte(input logic [7:0] b, input logic eoi);
    if (eoi || b == CH_LF || b == CH_CR) begin
      flag_error(ERR_UNTERM);
    end else if (b == CH_QUOTE) begin
      mode = MODE_FINISHED;
      push_result(KIND_END, 8'h00, ERR_UNTERM);
    end else if (b == CH_BSLASH) begin
      mode = MODE_ESCAPE;
    end else begin
      push_result(KIND_DATA, b, ERR_UNTERM);
    end
  endfunction

  function automatic void escape_byte(input logic [7:0] b, input logic eoi);
    logic [7:0] v;
    logic       hit;
    v = 8'h00;
    hit = 1'b1;
    if (eoi) begin
      flag_error(ERR_UNTERM);
      return;
    end
    case (b)
      CH_QUOTE:  v = CH_QUOTE;
      CH_APOS:   v = CH_APOS;
      CH_BSLASH: v = CH_BSLASH;
      "a":       v = 8'h07;
      "b":       v = 8'h08;
      "e":       v = CH_ESC;
      "f":       v = 8'h0c;
      "n":       v = CH_LF;
      "r":       v = CH_CR;
      "t":       v = 8'h09;
      "v":       v = 8'h0b;
      default:   hit = 1'b0;
    endcase
    if (hit) begin
      mode = MODE_NORMAL;
      push_result(KIND_DATA, v, ERR_UNTERM);
    end else if (b == "x") begin
      mode = MODE_HEX;
      acc = '0;
      ndig = '0;
    end else if (b == "u" || b == "U") begin
      mode = MODE_UNICODE;
      acc = '0;
      ndig = '0;
      nneed = (b == "u") ? 4'd4 : 4'd8;
    end else if (b >= "0" && b <= "9") begin
      mode = MODE_DECIMAL;
      acc = {17'd0, b[3:0]};
      ndig = 4'd1;
    end else begin
      flag_error(ERR_DECIMAL);
    end
  endfunction

  function automatic void emit_utf8(input logic [20:0] c);
    mode = MODE_NORMAL;
    if (c < 21'h80) begin
      push_result(KIND_DATA, c[7:0], ERR_UNTERM);
    end else if (c < 21'h800) begin
      push_result(KIND_DATA, {3'b110, c[10:6]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[5:0]}, ERR_UNTERM);
    end else if (c >= 21'h10000) begin
      push_result(KIND_DATA, {5'b11110, c[20:18]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[17:12]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[11:6]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[5:0]}, ERR_UNTERM);
    end else if (c >= 21'hd800 && c < 21'he000) begin
      flag_error(ERR_UNICODE);
    end else begin
      push_result(KIND_DATA, {4'b1110, c[15:12]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[11:6]}, ERR_UNTERM);
      push_result(KIND_DATA, {2'b10, c[5:0]}, ERR_UNTERM);
    end
  endfunction

  function automatic void decode_request(input logic [7:0] b, input logic fst,
                                         input logic eoi);
    logic [4:0]  hv;
    logic [24:0] wide;
    batch = 0;
    if (fst) begin
      mode = MODE_NORMAL;
      acc = '0;
      ndig = '0;
      nneed = '0;
    end
    case (mode)
      MODE_NORMAL: plain_byte(b, eoi);
      MODE_ESCAPE: escape_byte(b, eoi);
      MODE_HEX: begin
        hv = eoi ? 5'd0 : hex_value(b);
        if (!hv[4]) begin
          flag_error(ERR_HEX);
        end else if (ndig == 4'd0) begin
          acc = {17'd0, hv[3:0]};
          ndig = 4'd1;
        end else begin
          mode = MODE_NORMAL;
          push_result(KIND_DATA, {acc[3:0], hv[3:0]}, ERR_UNTERM);
        end
      end
      MODE_UNICODE: begin
        hv = eoi ? 5'd0 : hex_value(b);
        wide = {acc, hv[3:0]};
        acc = wide[20:0];
        if (!hv[4]) begin
          flag_error(ERR_UNICODE);
        end else if (wide >= CP_LIMIT) begin
          // range is checked after every digit, not just the last
          flag_error(ERR_UNICODE);
        end else begin
          ndig = ndig + 4'd1;
          if (ndig >= nneed) emit_utf8(acc);
        end
      end
      MODE_DECIMAL: begin
        if (!eoi && b >= "0" && b <= "9") begin
          acc = {13'd0, acc[7:0]} * 21'd10 + {17'd0, b[3:0]};
          ndig = ndig + 4'd1;
          if (ndig >= 4'd3) begin
            if (acc > 21'd255) begin
              flag_error(ERR_DECIMAL);
            end else begin
              mode = MODE_NORMAL;
              push_result(KIND_DATA, acc[7:0], ERR_UNTERM);
            end
          end
        end else begin
          // short escape: flush the value, then treat the byte as plain
          mode = MODE_NORMAL;
          push_result(KIND_DATA, acc[7:0], ERR_UNTERM);
          plain_byte(b, eoi);
        end
      end
      default: mode = MODE_FINISHED;
    endcase
    if (batch > 0) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_FINISHED;
      acc = '0;
      ndig = '0;
      nneed = '0;
      decoded_q.delete();
      fail_count = 0;
    end else begin
      // results at this edge come from earlier requests, so check first
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind=%0d data=%02h err=%0d last=%0b",
                     out_ch.kind, out_ch.data_byte, out_ch.error_code, out_ch.last);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.kind !== want.kind || out_ch.data_byte !== want.data_byte ||
              out_ch.error_code !== want.error_code || out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected kind=%0d data=%02h err=%0d last=%0b,",
                        " got kind=%0d data=%02h err=%0d last=%0b"},
                       want.kind, want.data_byte, want.error_code, want.last,
                       out_ch.kind, out_ch.data_byte, out_ch.error_code, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        decode_request(in_ch.source_byte, in_ch.first, in_ch.end_of_input);
    end
    pending = decoded_q.size();
  end

endmodule

// ===== test/string_literal_escape_decoder_test.sv =====
module string_literal_escape_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sed_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sed_in_if  req_ch ();
  sed_out_if res_ch ();

  int fail_count;
  int pending;
  int gap_pct;
  int stall_pct;
  int items_sent;
  int quiet_cycles;
  logic lead;

  string simple_set = "\"'\\abefnrtv";
  string nonhex_set = " g:/G@`~";
  string bad_esc_set = "qz?\n";

  string_literal_escape_decoder dut (
    .clk (clk),
    .rst (rst),
    .src (req_ch),
    .dst (res_ch)
  );

  string_literal_escape_decoder_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (req_ch),
    .out_ch     (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_req(input logic [7:0] b, input logic fst, input logic eoi,
                          input logic counted);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.source_byte  <= b;
    req_ch.first        <= fst;
    req_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_req(b, lead, 1'b0, 1'b1);
    lead = 1'b0;
  endtask

  task automatic put_eoi();
    send_req(8'($urandom_range(255)), lead, 1'b1, 1'b1);
    lead = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // hex digits of val, with a chance of a broken digit or an early end
  task automatic put_hex_digits(input logic [31:0] val, input int count);
    int bad_at;
    bad_at = ($urandom_range(99) < 8) ? $urandom_range(count - 1) : -1;
    for (int i = count - 1; i >= 0; i--) begin
      if (i == bad_at) begin
        if ($urandom_range(3) == 0) put_eoi();
        else put_byte(nonhex_set[$urandom_range(nonhex_set.len() - 1)]);
        return;
      end
      put_byte(hex_char(val[4*i +: 4]));
    end
  endtask

  task automatic put_token();
    int r;
    int nd;
    logic [7:0] b;
    logic [31:0] cp;
    r = $urandom_range(99);
    if (r < 30) begin
      b = 8'($urandom_range(255));
      if (b == CH_BSLASH || b == CH_QUOTE || b == CH_LF || b == CH_CR) b = "A" + b[3:0];
      put_byte(b);
    end else if (r < 45) begin
      put_byte(CH_BSLASH);
      put_byte(simple_set[$urandom_range(simple_set.len() - 1)]);
    end else if (r < 58) begin
      put_byte(CH_BSLASH);
      put_byte("x");
      put_hex_digits($urandom_range(255), 2);
    end else if (r < 80) begin
      case ($urandom_range(9))
        0, 1, 2: cp = $urandom_range(32'h7f);
        3, 4:    cp = $urandom_range(32'h7ff, 32'h80);
        5, 6:    cp = $urandom_range(32'hffff, 32'h800);
        7:       cp = $urandom_range(32'h10ffff, 32'h10000);
        8:       cp = $urandom_range(32'hdfff, 32'hd800);
        default: cp = $urandom | 32'h0011_0000;
      endcase
      nd = (cp > 32'hffff || $urandom_range(3) == 0) ? 8 : 4;
      put_byte(CH_BSLASH);
      put_byte((nd == 8) ? "U" : "u");
      put_hex_digits(cp, nd);
    end else if (r < 93) begin
      nd = $urandom_range(1, 3);
      cp = (nd == 3) ? $urandom_range(299) : (nd == 2) ? $urandom_range(99) : $urandom_range(9);
      put_byte(CH_BSLASH);
      if (nd == 3) put_byte(8'h30 + 8'(cp / 100));
      if (nd >= 2) put_byte(8'h30 + 8'((cp / 10) % 10));
      put_byte(8'h30 + 8'(cp % 10));
    end else begin
      // noise: any byte, sometimes restarting the literal midway
      if ($urandom_range(1)) lead = 1'b1;
      put_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_literal();
    int r;
    lead = 1'b1;
    repeat ($urandom_range(7)) put_token();
    r = $urandom_range(99);
    if (r < 78) begin
      put_byte(CH_QUOTE);
    end else if (r < 86) begin
      put_eoi();
    end else if (r < 92) begin
      put_byte(r[0] ? CH_LF : CH_CR);
    end else if (r < 96) begin
      put_byte(CH_BSLASH);
      put_byte(bad_esc_set[$urandom_range(bad_esc_set.len() - 1)]);
    end else begin
      put_byte(CH_BSLASH);
      put_eoi();
    end
    // trailing bytes without first are dropped by the block
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 3))
        send_req(8'($urandom_range(255)), 1'b0, $urandom_range(99) < 15, 1'b0);
  endtask

  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.source_byte  <= 8'h00;
    req_ch.first        <= 1'b0;
    req_ch.end_of_input <= 1'b0;
    gap_pct    = 12;
    stall_pct  = 81;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // byte extremes and a plain close
    lead = 1'b1;
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(CH_QUOTE);
    // end of input on the very first byte
    lead = 1'b1;
    put_eoi();
    // code point zero, then a raw CR
    lead = 1'b1;
    put_byte(CH_BSLASH); put_byte("u");
    put_byte("0"); put_byte("0"); put_byte("0"); put_byte("0");
    put_byte(CH_CR);
    // three-digit decimal above 255
    lead = 1'b1;
    put_byte(CH_BSLASH); put_byte("2"); put_byte("5"); put_byte("6");
    // short decimal cut by end of input
    lead = 1'b1;
    put_byte(CH_BSLASH); put_byte("7");
    put_eoi();
    // ignored while finished
    send_req("z", 1'b0, 1'b0, 1'b0);
    // three-byte UTF-8, escape char, close
    lead = 1'b1;
    put_byte(CH_BSLASH); put_byte("u");
    put_byte("2"); put_byte("0"); put_byte("A"); put_byte("c");
    put_byte(CH_BSLASH); put_byte("e");
    put_byte(CH_QUOTE);

    while (items_sent < 120) send_literal();
    gap_pct   = 81;
    stall_pct = 12;
    while (items_sent < 240) send_literal();
    gap_pct   = 0;
    stall_pct = 0;
    while (items_sent < 350) send_literal();
    req_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
